@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL files; block_in_edge_index_builder includes them.
// Each macro checks a property on the rising edge of clk, with rst_n low disabling it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property check: prop is a full property expression.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_CLK(name, prop, msg)
`define ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

@@ rtl/bieb_pkg.sv @@
package bieb_pkg;

  // Default table sizes.
  localparam int MAX_BLOCKS_DEF  = 1024;
  localparam int MAX_COLUMNS_DEF = 256;

  // Fixed field widths of the channels.
  localparam int OP_W     = 2;
  localparam int FACE_W   = 8;
  localparam int IDX_W    = 10;
  localparam int STATUS_W = 2;
  localparam int OWNER_W  = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
  localparam logic [OP_W-1:0] OP_RD_COL   = 2'd1;
  localparam logic [OP_W-1:0] OP_RD_LIST  = 2'd2;
  localparam logic [OP_W-1:0] OP_RD_OWNER = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_DONE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd2;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OWNER_W-1:0]  owner_column;
    logic [IDX_W-1:0]    in_start;
    logic [IDX_W-1:0]    in_count;
    logic [IDX_W-1:0]    in_block;
  } res_t;

endpackage

@@ rtl/bieb_if.sv @@
// Input channel: one load or read command per transfer.
interface bieb_in_if;
  logic                          valid;
  logic                          ready;
  logic [bieb_pkg::OP_W-1:0]     op;
  logic                          opens_column;
  logic [bieb_pkg::FACE_W-1:0]   facing_column;
  logic                          last_block;
  logic [bieb_pkg::IDX_W-1:0]    index;

  modport source (output valid, op, opens_column, facing_column, last_block, index,
                  input ready);
  modport sink (input valid, op, opens_column, facing_column, last_block, index,
                output ready);
endinterface

// Result channel: one result per read command.
interface bieb_out_if;
  logic                          valid;
  logic                          ready;
  logic [bieb_pkg::STATUS_W-1:0] status;
  logic [bieb_pkg::OWNER_W-1:0]  owner_column;
  logic [bieb_pkg::IDX_W-1:0]    in_start;
  logic [bieb_pkg::IDX_W-1:0]    in_count;
  logic [bieb_pkg::IDX_W-1:0]    in_block;

  modport source (output valid, status, owner_column, in_start, in_count, in_block,
                  input ready);
  modport sink (input valid, status, owner_column, in_start, in_count, in_block,
                output ready);
endinterface

@@ rtl/bieb_alu.sv @@
// Shared adder used by every counting, prefix and position step of the build.
module bieb_alu #(
  parameter int W = 11
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         cin,
  output logic [W-1:0] sum
);

  assign sum = a + b + W'(cin);

endmodule

@@ rtl/bieb_out_buf.sv @@
// Output register that holds one result until the receiver takes it.
module bieb_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bieb_pkg::res_t      push_data,
  output logic                free,
  bieb_out_if.source          out_ch
);

  logic           valid_r;
  bieb_pkg::res_t data_r;

  // The slot is free when empty or when its result transfers this cycle.
  assign free = !valid_r || out_ch.ready;

  // Valid flag follows pushes and transfers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload is captured on each push.
  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.status       = data_r.status;
  assign out_ch.owner_column = data_r.owner_column;
  assign out_ch.in_start     = data_r.in_start;
  assign out_ch.in_count     = data_r.in_count;
  assign out_ch.in_block     = data_r.in_block;

endmodule

@@ rtl/block_in_edge_index_builder.sv @@
// Builds per-column in-lists of a block-column sparse structure.
// in_ch carries commands: load a block (op 0) or read a column's offset and
// count (op 1), an in-list entry (op 2) or a block's owner column (op 3).
// out_ch carries one result per read; loads give none.
// A load is taken in the idle state and leaves in_ch ready. A read moves from
// its transfer to a read state that forms the result and pushes it into the
// output register, so a new read is not taken before the last one is pushed.
// The next command is taken while that result waits. The load marked last
// starts the build, during which in_ch is not ready. The build is sequenced
// over one shared adder and one read per column table per cycle: a clear pass
// over the columns, a counting pass over the blocks, a prefix-sum pass over the
// columns and a scatter pass over the blocks.
// A load after a finished build starts a new structure.
// Reset clears the counters and the done flag; no table is swept.
// If out_ch stalls, a second read waits with its result until the output
// register frees; in_ch then stays not ready.
module block_in_edge_index_builder #(
  parameter int MAX_BLOCKS  = bieb_pkg::MAX_BLOCKS_DEF,
  parameter int MAX_COLUMNS = bieb_pkg::MAX_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bieb_in_if.sink     in_ch,
  bieb_out_if.source  out_ch
);

  localparam int BW   = $clog2(MAX_BLOCKS);
  localparam int BLW  = $clog2(MAX_BLOCKS + 1);
  localparam int CW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CSW  = $clog2(MAX_COLUMNS + 1);
  localparam int CMP0 = (BLW > CSW) ? BLW : CSW;
  localparam int CMPW = (CMP0 > bieb_pkg::IDX_W) ? CMP0 : bieb_pkg::IDX_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_CLEAR,
    ST_CNT_A, ST_CNT_B, ST_CNT_C,
    ST_PRE_A, ST_PRE_B,
    ST_SCT_A, ST_SCT_B, ST_SCT_C, ST_SCT_D
  } state_t;

  // Sequencer state and counters.
  state_t                          state_r, state_nxt;
  logic [BLW-1:0]                  bl_r, bl_nxt;
  logic [CSW-1:0]                  cols_r, cols_nxt;
  logic [BLW-1:0]                  len_r, len_nxt;
  logic                            done_r, done_nxt;
  logic [BLW-1:0]                  b_r, b_nxt;
  logic [CSW-1:0]                  c_r, c_nxt;
  logic [BLW-1:0]                  sum_r, sum_nxt;
  logic [bieb_pkg::FACE_W-1:0]     f_r, f_nxt;
  logic                            fval_r, fval_nxt;
  logic [BLW-1:0]                  pos_r, pos_nxt;
  logic [bieb_pkg::OP_W-1:0]       op_r, op_nxt;
  logic [bieb_pkg::STATUS_W-1:0]   stat_r, stat_nxt;

  // Tables.
  logic [bieb_pkg::FACE_W-1:0] facing_mem [MAX_BLOCKS];
  logic [CW-1:0]               owner_mem  [MAX_BLOCKS];
  logic [BW-1:0]               list_mem   [MAX_BLOCKS];
  logic [BW-1:0]               first_mem  [MAX_COLUMNS];
  logic [BLW-1:0]              cnt_mem    [MAX_COLUMNS];
  logic [BLW-1:0]              off_mem    [MAX_COLUMNS];
  logic [BLW-1:0]              fill_mem   [MAX_COLUMNS];

  // Registered read data.
  logic [bieb_pkg::FACE_W-1:0] facing_rd_r;
  logic [CW-1:0]               owner_rd_r;
  logic [BW-1:0]               list_rd_r;
  logic [BW-1:0]               first_rd_r;
  logic [BLW-1:0]              cnt_rd_r;
  logic [BLW-1:0]              off_rd_r;
  logic [BLW-1:0]              fill_rd_r;

  // Table controls.
  logic                        blk_we;
  logic [BW-1:0]               blk_waddr;
  logic [bieb_pkg::FACE_W-1:0] facing_wdata;
  logic [CW-1:0]               owner_wdata;
  logic                        facing_re;
  logic [BW-1:0]               facing_raddr;
  logic                        idx_re;
  logic [BW-1:0]               idx_raddr;
  logic                        list_we;
  logic [BW-1:0]               list_waddr;
  logic [BW-1:0]               list_wdata;
  logic                        first_we;
  logic [CW-1:0]               first_waddr;
  logic [BW-1:0]               first_wdata;
  logic                        col_re;
  logic [CW-1:0]               col_raddr;
  logic                        cnt_we;
  logic [CW-1:0]               cnt_waddr;
  logic [BLW-1:0]              cnt_wdata;
  logic                        off_we;
  logic [CW-1:0]               off_waddr;
  logic                        fill_we;
  logic [CW-1:0]               fill_waddr;
  logic [BLW-1:0]              fill_wdata;

  // Shared adder.
  logic [BLW-1:0] alu_a, alu_b, alu_sum;
  logic           alu_cin;

  // Output register.
  logic           ob_push, ob_free;
  bieb_pkg::res_t ob_data;

  // Handshake helpers.
  logic           in_fire;
  logic           load_last_fire;
  logic           listed;
  logic [BLW-1:0] bl_eff;
  logic [CSW-1:0] cols_eff;
  logic           col_open;

  bieb_alu #(.W(BLW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .cin (alu_cin),
    .sum (alu_sum)
  );

  bieb_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ob_push),
    .push_data (ob_data),
    .free      (ob_free),
    .out_ch    (out_ch)
  );

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign load_last_fire = in_fire && (in_ch.op == bieb_pkg::OP_LOAD) && in_ch.last_block;

  // A load after a finished build starts from empty counters.
  assign bl_eff   = done_r ? '0 : bl_r;
  assign cols_eff = done_r ? '0 : cols_r;
  assign col_open = (in_ch.opens_column || (cols_eff == '0)) &&
                    (CMPW'(cols_eff) < CMPW'(MAX_COLUMNS));

  // A block is listed when its facing column exists and it is not that column's first.
  assign listed = fval_r && (BLW'(first_rd_r) != b_r);

  // Sequencer next-state and table control.
  always_comb begin
    state_nxt    = state_r;
    bl_nxt       = bl_r;
    cols_nxt     = cols_r;
    len_nxt      = len_r;
    done_nxt     = done_r;
    b_nxt        = b_r;
    c_nxt        = c_r;
    sum_nxt      = sum_r;
    f_nxt        = f_r;
    fval_nxt     = fval_r;
    pos_nxt      = pos_r;
    op_nxt       = op_r;
    stat_nxt     = stat_r;
    blk_we       = 1'b0;
    blk_waddr    = BW'(bl_eff);
    facing_wdata = in_ch.facing_column;
    owner_wdata  = col_open ? CW'(cols_eff) : CW'(cols_eff - 1'b1);
    facing_re    = 1'b0;
    facing_raddr = BW'(b_r);
    idx_re       = 1'b0;
    idx_raddr    = BW'(in_ch.index);
    list_we      = 1'b0;
    list_waddr   = BW'(pos_r);
    list_wdata   = BW'(b_r);
    first_we     = 1'b0;
    first_waddr  = CW'(cols_eff);
    first_wdata  = BW'(bl_eff);
    col_re       = 1'b0;
    col_raddr    = CW'(c_r);
    cnt_we       = 1'b0;
    cnt_waddr    = CW'(c_r);
    cnt_wdata    = '0;
    off_we       = 1'b0;
    off_waddr    = CW'(c_r);
    fill_we      = 1'b0;
    fill_waddr   = CW'(c_r);
    fill_wdata   = '0;
    alu_a        = '0;
    alu_b        = '0;
    alu_cin      = 1'b0;
    ob_push      = 1'b0;
    ob_data      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.op == bieb_pkg::OP_LOAD) begin
            if (done_r) begin
              len_nxt  = '0;
              done_nxt = 1'b0;
            end
            bl_nxt   = bl_eff;
            cols_nxt = cols_eff;
            if (CMPW'(bl_eff) < CMPW'(MAX_BLOCKS)) begin
              blk_we = 1'b1;
              bl_nxt = bl_eff + 1'b1;
              if (col_open) begin
                first_we = 1'b1;
                cols_nxt = cols_eff + 1'b1;
              end
            end
            if (in_ch.last_block) begin
              c_nxt     = '0;
              state_nxt = ST_CLEAR;
            end
          end else begin
            // Read command: check the range and fetch from the tables.
            op_nxt    = in_ch.op;
            col_raddr = CW'(in_ch.index);
            col_re    = 1'b1;
            idx_re    = 1'b1;
            priority if (!done_r) begin
              stat_nxt = bieb_pkg::STAT_NOT_DONE;
            end else if (in_ch.op == bieb_pkg::OP_RD_COL) begin
              stat_nxt = (CMPW'(in_ch.index) < CMPW'(cols_r)) ?
                         bieb_pkg::STAT_OK : bieb_pkg::STAT_RANGE;
            end else if (in_ch.op == bieb_pkg::OP_RD_LIST) begin
              stat_nxt = (CMPW'(in_ch.index) < CMPW'(len_r)) ?
                         bieb_pkg::STAT_OK : bieb_pkg::STAT_RANGE;
            end else begin
              stat_nxt = (CMPW'(in_ch.index) < CMPW'(bl_r)) ?
                         bieb_pkg::STAT_OK : bieb_pkg::STAT_RANGE;
            end
            state_nxt = ST_READ;
          end
        end
      end

      ST_READ: begin
        // Form the result; fields stay zero unless the status is ok.
        ob_data.status = stat_r;
        if (stat_r == bieb_pkg::STAT_OK) begin
          unique case (op_r)
            bieb_pkg::OP_RD_COL: begin
              ob_data.in_start = bieb_pkg::IDX_W'(off_rd_r);
              ob_data.in_count = bieb_pkg::IDX_W'(cnt_rd_r);
            end
            bieb_pkg::OP_RD_LIST: begin
              ob_data.in_block = bieb_pkg::IDX_W'(list_rd_r);
            end
            bieb_pkg::OP_RD_OWNER: begin
              ob_data.owner_column = bieb_pkg::OWNER_W'(owner_rd_r);
            end
            bieb_pkg::OP_LOAD: begin
              ob_data.status = stat_r;
            end
          endcase
        end
        if (ob_free) begin
          ob_push   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_CLEAR: begin
        // Zero counts and fill cursors of every opened column.
        if (c_r == cols_r) begin
          b_nxt     = '0;
          state_nxt = ST_CNT_A;
        end else begin
          cnt_we  = 1'b1;
          fill_we = 1'b1;
          c_nxt   = c_r + 1'b1;
        end
      end

      ST_CNT_A: begin
        if (b_r == bl_r) begin
          c_nxt     = '0;
          sum_nxt   = '0;
          state_nxt = ST_PRE_A;
        end else begin
          facing_re = 1'b1;
          state_nxt = ST_CNT_B;
        end
      end

      ST_CNT_B: begin
        f_nxt     = facing_rd_r;
        fval_nxt  = CMPW'(facing_rd_r) < CMPW'(cols_r);
        col_raddr = CW'(facing_rd_r);
        col_re    = 1'b1;
        state_nxt = ST_CNT_C;
      end

      ST_CNT_C: begin
        // Count the block against its facing column.
        alu_a     = cnt_rd_r;
        alu_cin   = 1'b1;
        cnt_we    = listed;
        cnt_waddr = CW'(f_r);
        cnt_wdata = alu_sum;
        b_nxt     = b_r + 1'b1;
        state_nxt = ST_CNT_A;
      end

      ST_PRE_A: begin
        if (c_r == cols_r) begin
          len_nxt   = sum_r;
          b_nxt     = '0;
          state_nxt = ST_SCT_A;
        end else begin
          col_re    = 1'b1;
          state_nxt = ST_PRE_B;
        end
      end

      ST_PRE_B: begin
        // Running prefix sum gives the column start offset.
        alu_a     = sum_r;
        alu_b     = cnt_rd_r;
        off_we    = 1'b1;
        sum_nxt   = alu_sum;
        c_nxt     = c_r + 1'b1;
        state_nxt = ST_PRE_A;
      end

      ST_SCT_A: begin
        if (b_r == bl_r) begin
          done_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          facing_re = 1'b1;
          state_nxt = ST_SCT_B;
        end
      end

      ST_SCT_B: begin
        f_nxt     = facing_rd_r;
        fval_nxt  = CMPW'(facing_rd_r) < CMPW'(cols_r);
        col_raddr = CW'(facing_rd_r);
        col_re    = 1'b1;
        state_nxt = ST_SCT_C;
      end

      ST_SCT_C: begin
        // List position is the column offset plus its fill cursor.
        alu_a     = off_rd_r;
        alu_b     = fill_rd_r;
        pos_nxt   = alu_sum;
        fval_nxt  = listed;
        state_nxt = ST_SCT_D;
      end

      ST_SCT_D: begin
        // Place the block and advance the column's fill cursor.
        alu_a      = fill_rd_r;
        alu_cin    = 1'b1;
        list_we    = fval_r;
        fill_we    = fval_r;
        fill_waddr = CW'(f_r);
        fill_wdata = alu_sum;
        b_nxt      = b_r + 1'b1;
        state_nxt  = ST_SCT_A;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bl_r    <= '0;
      cols_r  <= '0;
      len_r   <= '0;
      done_r  <= 1'b0;
      b_r     <= '0;
      c_r     <= '0;
    end else begin
      state_r <= state_nxt;
      bl_r    <= bl_nxt;
      cols_r  <= cols_nxt;
      len_r   <= len_nxt;
      done_r  <= done_nxt;
      b_r     <= b_nxt;
      c_r     <= c_nxt;
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    f_r    <= f_nxt;
    fval_r <= fval_nxt;
    pos_r  <= pos_nxt;
    op_r   <= op_nxt;
    stat_r <= stat_nxt;
  end

  // Per-block facing and owner tables.
  always_ff @(posedge clk) begin
    if (blk_we) begin
      facing_mem[blk_waddr] <= facing_wdata;
      owner_mem[blk_waddr]  <= owner_wdata;
    end
    if (facing_re) begin
      facing_rd_r <= facing_mem[facing_raddr];
    end
    if (idx_re) begin
      owner_rd_r <= owner_mem[idx_raddr];
    end
  end

  // In-list table.
  always_ff @(posedge clk) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    if (idx_re) begin
      list_rd_r <= list_mem[idx_raddr];
    end
  end

  // Column first-block table.
  always_ff @(posedge clk) begin
    if (first_we) begin
      first_mem[first_waddr] <= first_wdata;
    end
    if (col_re) begin
      first_rd_r <= first_mem[col_raddr];
    end
  end

  // Column count table.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (col_re) begin
      cnt_rd_r <= cnt_mem[col_raddr];
    end
  end

  // Column offset table.
  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[off_waddr] <= sum_r;
    end
    if (col_re) begin
      off_rd_r <= off_mem[col_raddr];
    end
  end

  // Column fill cursor table.
  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (col_re) begin
      fill_rd_r <= fill_mem[col_raddr];
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_push_free, ob_push |-> ob_free, "result pushed into a busy output register")
  `ASSERT_CLK(a_len_bound, done_r |-> (len_r <= bl_r), "in-list longer than blocks loaded")
  `ASSERT_CLK(a_bl_bound, bl_r <= BLW'(MAX_BLOCKS), "block count beyond table size")
  `ASSERT_NEXT(a_last_builds, load_last_fire, state_r == ST_CLEAR, "build did not start")

endmodule
